/* hw/rtl/sum_checked_frame_receiver_top_macros.svh */
// assertion macros for the sum-checked frame receiver
// used by scfr_core and scfr_out_stage, expects clk_i and rst_ni in scope
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// checked only out of reset
`define SCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/scfr_pkg.sv */
// shared types and constants for the sum-checked frame receiver
// no dependencies
`default_nettype none

package scfr_pkg;

  localparam logic [31:0] HEADER_RESET = 32'h024D_6C02;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_HDR   = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_DST   = 8'b0000_0010,
    PH_SRC   = 8'b0000_0100,
    PH_LEN   = 8'b0000_1000,
    PH_PAY   = 8'b0001_0000,
    PH_SUMLO = 8'b0010_0000,
    PH_SUMHI = 8'b0100_0000,
    PH_IDLE  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_start;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic [7:0] frame_len;
    logic [1:0] status;
    logic       last;
  } result_t;

  // header byte k, first byte in the top bits
  function automatic logic [7:0] hdr_byte(input logic [31:0] word, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = word[31:24];
      2'd1:    r = word[23:16];
      2'd2:    r = word[15:8];
      default: r = word[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/scfr_in_stage.sv */
// input register of the sum-checked frame receiver
// depends on scfr_pkg
`default_nettype none

module scfr_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     rx_byte_i,
  input  wire logic           buffer_start_i,
  input  wire logic           out_free_i,
  output logic                fire_o,
  output scfr_pkg::item_t     item_o
);

  logic            in_valid_q;
  scfr_pkg::item_t item_q;
  logic            accept;

  assign fire_o     = in_valid_q & out_free_i;
  assign in_stall_o = in_valid_q & ~out_free_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire_o) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.rx_byte      <= rx_byte_i;
      item_q.buffer_start <= buffer_start_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scfr_core.sv */
// frame parser: header hunt, address and length capture, check sum
// depends on scfr_pkg and the assertion macro header
`default_nettype none

`include "sum_checked_frame_receiver_top_macros.svh"

module scfr_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              fire_i,
  input  wire scfr_pkg::item_t   item_i,
  output logic                   res_valid_o,
  output scfr_pkg::result_t      res_o
);

  logic [31:0]      header_q;
  scfr_pkg::phase_e phase_q, phase_d, ph;
  logic [2:0]       hunt_pos_q, hunt_pos_d, pos, pos_m1;
  logic             m0_q, m0_d, m1_q, m1_d, m0, m1, m0n, m1n;
  logic [7:0]       dest_q, dest_d, source_q, source_d, length_q, length_d;
  logic [7:0]       remaining_q, remaining_d;
  logic [15:0]      sum_q, sum_d, sum_add;
  logic [7:0]       sum_lo_q, sum_lo_d;
  logic [7:0]       b;

  assign b       = item_i.rx_byte;
  assign pos_m1  = pos - 3'd1;
  assign sum_add = sum_q + {8'd0, ~b} + {b, 8'd0};

  always_comb begin
    ph  = phase_q;
    pos = hunt_pos_q;
    m0  = m0_q;
    m1  = m1_q;
    if (item_i.buffer_start) begin
      ph  = scfr_pkg::PH_HUNT;
      pos = 3'd0;
      m0  = 1'b1;
      m1  = 1'b1;
    end
  end

  assign m0n = m0 & ~((pos <= 3'd3) && (b != scfr_pkg::hdr_byte(header_q, pos[1:0])));
  assign m1n = m1 & ~((pos >= 3'd1) && (b != scfr_pkg::hdr_byte(header_q, pos_m1[1:0])));

  always_comb begin
    phase_d     = phase_q;
    hunt_pos_d  = hunt_pos_q;
    m0_d        = m0_q;
    m1_d        = m1_q;
    dest_d      = dest_q;
    source_d    = source_q;
    length_d    = length_q;
    remaining_d = remaining_q;
    sum_d       = sum_q;
    sum_lo_d    = sum_lo_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      phase_d    = ph;
      hunt_pos_d = pos;
      m0_d       = m0;
      m1_d       = m1;
      case (ph)
        scfr_pkg::PH_HUNT: begin
          m0_d = m0n;
          m1_d = m1n;
          if (((pos == 3'd3) && m0n) || ((pos == 3'd4) && m1n)) begin
            phase_d = scfr_pkg::PH_DST;
            sum_d   = '0;
          end else if (!m0n && !m1n) begin
            phase_d      = scfr_pkg::PH_IDLE;
            res_valid_o  = 1'b1;
            res_o.kind   = scfr_pkg::KIND_STATUS;
            res_o.status = scfr_pkg::STATUS_NO_HDR;
            res_o.last   = 1'b1;
          end else begin
            hunt_pos_d = pos + 3'd1;
          end
        end
        scfr_pkg::PH_DST: begin
          dest_d  = b;
          sum_d   = sum_add;
          phase_d = scfr_pkg::PH_SRC;
        end
        scfr_pkg::PH_SRC: begin
          source_d = b;
          sum_d    = sum_add;
          phase_d  = scfr_pkg::PH_LEN;
        end
        scfr_pkg::PH_LEN: begin
          length_d    = b;
          remaining_d = b;
          sum_d       = sum_add;
          phase_d     = (b == 8'd0) ? scfr_pkg::PH_SUMLO : scfr_pkg::PH_PAY;
        end
        scfr_pkg::PH_PAY: begin
          sum_d       = sum_add;
          remaining_d = remaining_q - 8'd1;
          if (remaining_q == 8'd1) begin
            phase_d = scfr_pkg::PH_SUMLO;
          end
          res_valid_o        = 1'b1;
          res_o.kind         = scfr_pkg::KIND_PAYLOAD;
          res_o.payload_byte = b;
          res_o.src_addr     = source_q;
          res_o.dst_addr     = dest_q;
          res_o.frame_len    = length_q;
          res_o.status       = scfr_pkg::STATUS_OK;
        end
        scfr_pkg::PH_SUMLO: begin
          sum_lo_d = b;
          phase_d  = scfr_pkg::PH_SUMHI;
        end
        scfr_pkg::PH_SUMHI: begin
          phase_d         = scfr_pkg::PH_IDLE;
          res_valid_o     = 1'b1;
          res_o.kind      = scfr_pkg::KIND_STATUS;
          res_o.src_addr  = source_q;
          res_o.dst_addr  = dest_q;
          res_o.frame_len = length_q;
          res_o.status    = ({b, sum_lo_q} == sum_q) ? scfr_pkg::STATUS_OK
                                                     : scfr_pkg::STATUS_MISMATCH;
          res_o.last      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= scfr_pkg::HEADER_RESET;
      phase_q     <= scfr_pkg::PH_HUNT;
      hunt_pos_q  <= 3'd0;
      m0_q        <= 1'b1;
      m1_q        <= 1'b1;
      dest_q      <= '0;
      source_q    <= '0;
      length_q    <= '0;
      remaining_q <= '0;
      sum_q       <= '0;
      sum_lo_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        header_q <= cfg_data_i;
      end
      phase_q     <= phase_d;
      hunt_pos_q  <= hunt_pos_d;
      m0_q        <= m0_d;
      m1_q        <= m1_d;
      dest_q      <= dest_d;
      source_q    <= source_d;
      length_q    <= length_d;
      remaining_q <= remaining_d;
      sum_q       <= sum_d;
      sum_lo_q    <= sum_lo_d;
    end
  end

  `SCFR_ASSERT(a_start_restarts_hunt, fire_i && item_i.buffer_start |=> phase_q == scfr_pkg::PH_HUNT && hunt_pos_q == 3'd1, "buffer start did not restart the header hunt")
  `SCFR_ASSERT(a_pay_has_bytes_left, phase_q == scfr_pkg::PH_PAY |-> remaining_q != 8'd0, "payload phase with no bytes left")
  `SCFR_ASSERT(a_sum_hi_ends_frame, fire_i && !item_i.buffer_start && phase_q == scfr_pkg::PH_SUMHI |=> phase_q == scfr_pkg::PH_IDLE, "frame did not end after the sum")

endmodule

`default_nettype wire

/* hw/rtl/scfr_out_stage.sv */
// result register of the sum-checked frame receiver
// depends on scfr_pkg and the assertion macro header
`default_nettype none

`include "sum_checked_frame_receiver_top_macros.svh"

module scfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire scfr_pkg::result_t res_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output scfr_pkg::result_t      res_o
);

  logic              out_valid_q;
  scfr_pkg::result_t res_q;

  assign out_free_o  = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_free_o) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  `SCFR_ASSERT_ALWAYS(a_reset_clears_out, !rst_ni |=> !out_valid_q, "item shown right after reset")
  `SCFR_ASSERT(a_load_only_when_free, load_i |-> out_free_o, "item loaded over a held item")
  `SCFR_ASSERT(a_status_is_last, out_valid_q |-> res_q.last == res_q.kind, "last flag and kind disagree")

endmodule

`default_nettype wire

/* hw/rtl/sum_checked_frame_receiver_top.sv */
// Sum-checked frame receiver. Takes one received byte per item and
// returns payload bytes and one status item per frame. Each item passes an
// input register, the parsing logic (header compare and a 16-bit sum add)
// and a result register, so one item is accepted every cycle unless the
// output stalls.
// The header word is written through the cfg port, which is always ready;
// write it only while no item is in flight.
`default_nettype none

module sum_checked_frame_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        buffer_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [7:0]       src_addr_o,
  output logic [7:0]       dst_addr_o,
  output logic [7:0]       frame_len_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  logic              out_free;
  logic              fire;
  logic              res_valid;
  scfr_pkg::item_t   item;
  scfr_pkg::result_t res, res_out;

  assign cfg_ready_o = 1'b1;

  scfr_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .buffer_start_i,
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (item)
  );

  scfr_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i,
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scfr_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i      (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o,
    .out_stall_i,
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign payload_byte_o = res_out.payload_byte;
  assign src_addr_o     = res_out.src_addr;
  assign dst_addr_o     = res_out.dst_addr;
  assign frame_len_o    = res_out.frame_len;
  assign status_o       = res_out.status;
  assign last_o         = res_out.last;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench for sum_checked_frame_receiver_top: directed and random frames,
// header writes and output hold-off, checked against an in-bench frame parser
// depends on scfr_pkg and the receiver rtl
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  rx_byte_i      = '0;
  logic        buffer_start_i = 1'b0;
  logic        out_stall_i    = 1'b0;
  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  src_addr_o;
  logic [7:0]  dst_addr_o;
  logic [7:0]  frame_len_o;
  logic [1:0]  status_o;
  logic        last_o;

  sum_checked_frame_receiver_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .buffer_start_i (buffer_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .src_addr_o     (src_addr_o),
    .dst_addr_o     (dst_addr_o),
    .frame_len_o    (frame_len_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // parser state
  logic [31:0]      hunt_hdr = scfr_pkg::HEADER_RESET;
  scfr_pkg::phase_e fr_phase = scfr_pkg::PH_HUNT;
  logic [2:0]       hunt_idx = '0;
  logic             hit0     = 1'b1;
  logic             hit1     = 1'b1;
  logic [7:0]       fr_dst   = '0;
  logic [7:0]       fr_src   = '0;
  logic [7:0]       fr_len   = '0;
  logic [7:0]       fr_left  = '0;
  logic [15:0]      fr_sum   = '0;
  logic [7:0]       sum_lo   = '0;

  scfr_pkg::result_t frame_out_q[$];
  scfr_pkg::item_t   buf_q[$];
  logic [31:0] hdr_now     = scfr_pkg::HEADER_RESET;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  int          hold_left   = 0;
  int          rx_wait     = 0;
  int          errors      = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  int          cfg_writes  = 0;
  int          n_payload   = 0;
  int          n_ok        = 0;
  int          n_bad       = 0;
  int          n_nohdr     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] sum_term(input logic [7:0] b);
    return {8'h00, b ^ 8'hFF} + {b, 8'h00};
  endfunction

  function automatic logic [7:0] hunt_byte(input logic [2:0] k);
    return hunt_hdr[8 * (3 - k[1:0]) +: 8];
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic bs);
    scfr_pkg::result_t r;
    bit                emit;
    r    = '0;
    emit = 1'b0;
    if (bs) begin
      fr_phase = scfr_pkg::PH_HUNT;
      hunt_idx = '0;
      hit0     = 1'b1;
      hit1     = 1'b1;
    end
    case (fr_phase)
      scfr_pkg::PH_HUNT: begin
        if (hunt_idx <= 3 && b != hunt_byte(hunt_idx)) hit0 = 1'b0;
        if (hunt_idx >= 1 && b != hunt_byte(hunt_idx - 3'd1)) hit1 = 1'b0;
        if ((hunt_idx == 3 && hit0) || (hunt_idx == 4 && hit1)) begin
          fr_phase = scfr_pkg::PH_DST;
          fr_sum   = '0;
        end else if (!hit0 && !hit1) begin
          fr_phase = scfr_pkg::PH_IDLE;
          r.kind   = scfr_pkg::KIND_STATUS;
          r.status = scfr_pkg::STATUS_NO_HDR;
          r.last   = 1'b1;
          emit     = 1'b1;
        end else begin
          hunt_idx = hunt_idx + 3'd1;
        end
      end
      scfr_pkg::PH_DST: begin
        fr_dst   = b;
        fr_sum   = fr_sum + sum_term(b);
        fr_phase = scfr_pkg::PH_SRC;
      end
      scfr_pkg::PH_SRC: begin
        fr_src   = b;
        fr_sum   = fr_sum + sum_term(b);
        fr_phase = scfr_pkg::PH_LEN;
      end
      scfr_pkg::PH_LEN: begin
        fr_len   = b;
        fr_left  = b;
        fr_sum   = fr_sum + sum_term(b);
        fr_phase = (b == 8'd0) ? scfr_pkg::PH_SUMLO : scfr_pkg::PH_PAY;
      end
      scfr_pkg::PH_PAY: begin
        fr_sum  = fr_sum + sum_term(b);
        fr_left = fr_left - 8'd1;
        if (fr_left == 8'd0) fr_phase = scfr_pkg::PH_SUMLO;
        r.kind         = scfr_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.src_addr     = fr_src;
        r.dst_addr     = fr_dst;
        r.frame_len    = fr_len;
        r.status       = scfr_pkg::STATUS_OK;
        emit           = 1'b1;
      end
      scfr_pkg::PH_SUMLO: begin
        sum_lo   = b;
        fr_phase = scfr_pkg::PH_SUMHI;
      end
      scfr_pkg::PH_SUMHI: begin
        fr_phase    = scfr_pkg::PH_IDLE;
        r.kind      = scfr_pkg::KIND_STATUS;
        r.src_addr  = fr_src;
        r.dst_addr  = fr_dst;
        r.frame_len = fr_len;
        r.status    = ({b, sum_lo} == fr_sum) ? scfr_pkg::STATUS_OK
                                              : scfr_pkg::STATUS_MISMATCH;
        r.last      = 1'b1;
        emit        = 1'b1;
      end
      default: begin
      end
    endcase
    if (emit) frame_out_q.push_back(r);
  endtask

  task automatic flag_error(input string what, input scfr_pkg::result_t exp,
                            input scfr_pkg::result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0s at %0t: expected kind=%0d byte=%02h src=%02h dst=%02h len=%0d st=%0d last=%0d",
               what, $time, exp.kind, exp.payload_byte, exp.src_addr, exp.dst_addr,
               exp.frame_len, exp.status, exp.last);
      $display("    got kind=%0d byte=%02h src=%02h dst=%02h len=%0d st=%0d last=%0d",
               got.kind, got.payload_byte, got.src_addr, got.dst_addr, got.frame_len,
               got.status, got.last);
    end
  endtask

  // output check first, then the parser for the item taken at the same edge
  always @(posedge clk_i) begin : monitor
    scfr_pkg::result_t got;
    scfr_pkg::result_t exp;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {kind_o, payload_byte_o, src_addr_o, dst_addr_o, frame_len_o, status_o, last_o};
        if (frame_out_q.size() == 0) begin
          flag_error("unexpected item", '0, got);
        end else begin
          exp = frame_out_q.pop_front();
          if (exp.kind == scfr_pkg::KIND_PAYLOAD) n_payload++;
          else if (exp.status == scfr_pkg::STATUS_OK) n_ok++;
          else if (exp.status == scfr_pkg::STATUS_MISMATCH) n_bad++;
          else n_nohdr++;
          if (got.kind !== exp.kind || got.payload_byte !== exp.payload_byte ||
              got.src_addr !== exp.src_addr || got.dst_addr !== exp.dst_addr ||
              got.frame_len !== exp.frame_len || got.status !== exp.status ||
              got.last !== exp.last)
            flag_error("mismatch", exp, got);
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (in_valid_i && !in_stall_o) parse_byte(rx_byte_i, buffer_start_i);
    end
  end

  // receiver side: long hold-off first, then the per-item wait
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_stall_i = 1'b1;
      rx_wait--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task automatic send_item(input scfr_pkg::item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    rx_byte_i      = it.rx_byte;
    buffer_start_i = it.buffer_start;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (frame_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [31:0] w);
    wait_quiet();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = w;
    do @(posedge clk_i); while (!cfg_ready_o);
    hunt_hdr = w;
    hdr_now  = w;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic bs);
    scfr_pkg::item_t it;
    it.rx_byte      = b;
    it.buffer_start = bs;
    buf_q.push_back(it);
  endtask

  task automatic add_frame(input bit offset1, input logic [7:0] prefix, input logic [7:0] dst,
                           input logic [7:0] src, input logic [7:0] len, input bit bad_sum,
                           input bit mark_start);
    logic [15:0] s;
    logic [7:0]  pb;
    bit          first;
    first = mark_start;
    if (offset1) begin
      add_byte(prefix, first);
      first = 1'b0;
    end
    for (int k = 0; k < 4; k++) begin
      add_byte(hdr_now[8 * (3 - k) +: 8], first);
      first = 1'b0;
    end
    add_byte(dst, 1'b0);
    add_byte(src, 1'b0);
    add_byte(len, 1'b0);
    s = sum_term(dst) + sum_term(src) + sum_term(len);
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom);
      add_byte(pb, 1'b0);
      s = s + sum_term(pb);
    end
    if (bad_sum) s = s ^ 16'($urandom_range(1, 65535));
    add_byte(s[7:0], 1'b0);
    add_byte(s[15:8], 1'b0);
  endtask

  task automatic flush_buffer();
    foreach (buf_q[i]) send_item(buf_q[i]);
    buf_q.delete();
  endtask

  task automatic random_buffer();
    int          pick;
    int          n;
    int          j;
    logic [7:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      n = $urandom_range(0, 99);
      if (n < 94) len = 8'($urandom_range(0, 12));
      else if (n < 99) len = 8'($urandom_range(13, 64));
      else len = 8'd255;
      add_frame(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom), len,
                $urandom_range(0, 4) == 0, 1'b1);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, buf_q.size() - 1)) void'(buf_q.pop_back());
      else
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
    end else if (pick < 90) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom), i == 0 || $urandom_range(0, 3) == 0);
    end else begin
      // header with one damaged byte
      j = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) add_byte(8'($urandom), 1'b1);
      for (int k = 0; k < 4; k++)
        add_byte(hdr_now[8 * (3 - k) +: 8] ^ ((k == j) ? 8'($urandom_range(1, 255)) : 8'h00),
                 buf_q.size() == 0);
      repeat (3) add_byte(8'($urandom), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
    if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
    flush_buffer();
  endtask

  task automatic test_default_header();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // first bytes after reset carry no buffer start
    add_frame(1'b0, 8'h00, 8'h00, 8'hFF, 8'd0, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_frame(1'b1, 8'hFF, 8'hFF, 8'h00, 8'd1, 1'b1, 1'b1);
    add_byte(8'h02, 1'b1);
    add_byte(8'h00, 1'b0);
    flush_buffer();
  endtask

  task automatic test_header_config();
    // all-zero header matches at both offsets, offset 0 wins
    write_header(32'h0000_0000);
    add_frame(1'b1, 8'h00, 8'h12, 8'h34, 8'd2, 1'b0, 1'b1);
    flush_buffer();
    write_header(32'hFFFF_FFFF);
    add_frame(1'b1, 8'h00, 8'hFF, 8'hFF, 8'd3, 1'b0, 1'b1);
    // offset 1 survives until byte 4, then no header
    add_byte(8'h00, 1'b1);
    repeat (3) add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    flush_buffer();
    write_header(scfr_pkg::HEADER_RESET);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    wait_quiet();
    hold_left = 150;
    add_frame(1'b0, 8'h00, 8'($urandom), 8'($urandom), 8'd255, 1'b0, 1'b1);
    flush_buffer();
    wait_quiet();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          base;
    logic [31:0] hdr;
    base = items_sent;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       hdr = scfr_pkg::HEADER_RESET;
        1:       hdr = 32'hFFFF_FFFF;
        3:       hdr = 32'h0000_0000;
        default: hdr = $urandom;
      endcase
      write_header(hdr);
      while (items_sent - base < (p + 1) * RANDOM_ITEMS / 5) random_buffer();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_header();
    test_header_config();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    $display("%0d bytes sent over %0d header settings; %0d payload items checked",
             items_sent, cfg_writes, n_payload);
    $display("frame status: %0d ok, %0d sum mismatch, %0d no header", n_ok, n_bad, n_nohdr);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
